@@ hw/rtl/tbpc_pkg.sv @@
// Package for the tilt balance PID controller.
// Shared types, codes and fixed-point constants. No dependencies.
package tbpc_pkg;

  localparam int FILTER_COEF = 65451;
  localparam int FILTER_COMP = 65536 - FILTER_COEF;
  localparam int MIN_PULSE   = 1000;
  localparam int DT_Q32      = 4294967;
  localparam int DUTY_GAIN   = 11008737;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_TARGET_ANGLE,
    REG_ACCEL_SCALE,
    REG_GYRO_SCALE,
    REG_ACCEL_BIAS,
    REG_GYRO_BIAS
  } reg_index_t;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_ACC,
    MS_RATE,
    MS_INC,
    MS_MIX1,
    MS_MIX2,
    MS_P,
    MS_I,
    MS_D,
    MS_DL,
    MS_DH
  } mul_sel_t;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_ACC,
    WR_RATE,
    WR_SUM,
    WR_ACCUM,
    WR_TILT,
    WR_SEED,
    WR_ERR,
    WR_PTERM,
    WR_INTEG,
    WR_PD,
    WR_U,
    WR_ABS,
    WR_OUT
  } wr_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_ACC,
    ST_M_RATE,
    ST_W_RATE,
    ST_SEED,
    ST_M_INC,
    ST_W_INC,
    ST_M_MIX1,
    ST_M_MIX2,
    ST_W_MIX,
    ST_ERR,
    ST_M_P,
    ST_M_I,
    ST_M_D,
    ST_W_PD,
    ST_W_U,
    ST_ABS,
    ST_M_DL,
    ST_M_DH,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    wr_sel_t  wr_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic seeded;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ hw/rtl/tbpc_ctrl.sv @@
// Sequencer for the tilt balance PID controller.
// Steps the datapath through one sample; uses tbpc_pkg.
module tbpc_ctrl
  import tbpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.load_in = 1'b0;
    cmd.mul_sel = MS_NONE;
    cmd.wr_sel  = WR_NONE;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_M_ACC;
        end
      end
      ST_M_ACC: begin
        cmd.mul_sel = MS_ACC;
        state_next  = ST_M_RATE;
      end
      ST_M_RATE: begin
        cmd.mul_sel = MS_RATE;
        cmd.wr_sel  = WR_ACC;
        state_next  = stat.seeded ? ST_W_RATE : ST_SEED;
      end
      ST_W_RATE: begin
        cmd.wr_sel = WR_RATE;
        state_next = ST_M_INC;
      end
      ST_SEED: begin
        cmd.wr_sel = WR_SEED;
        state_next = ST_ERR;
      end
      ST_M_INC: begin
        cmd.mul_sel = MS_INC;
        state_next  = ST_W_INC;
      end
      ST_W_INC: begin
        cmd.wr_sel = WR_SUM;
        state_next = ST_M_MIX1;
      end
      ST_M_MIX1: begin
        cmd.mul_sel = MS_MIX1;
        state_next  = ST_M_MIX2;
      end
      ST_M_MIX2: begin
        cmd.mul_sel = MS_MIX2;
        cmd.wr_sel  = WR_ACCUM;
        state_next  = ST_W_MIX;
      end
      ST_W_MIX: begin
        cmd.wr_sel = WR_TILT;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.wr_sel = WR_ERR;
        state_next = ST_M_P;
      end
      ST_M_P: begin
        cmd.mul_sel = MS_P;
        state_next  = ST_M_I;
      end
      ST_M_I: begin
        cmd.mul_sel = MS_I;
        cmd.wr_sel  = WR_PTERM;
        state_next  = ST_M_D;
      end
      ST_M_D: begin
        cmd.mul_sel = MS_D;
        cmd.wr_sel  = WR_INTEG;
        state_next  = ST_W_PD;
      end
      ST_W_PD: begin
        cmd.wr_sel = WR_PD;
        state_next = ST_W_U;
      end
      ST_W_U: begin
        cmd.wr_sel = WR_U;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.wr_sel = WR_ABS;
        state_next = ST_M_DL;
      end
      ST_M_DL: begin
        cmd.mul_sel = MS_DL;
        state_next  = ST_M_DH;
      end
      ST_M_DH: begin
        cmd.mul_sel = MS_DH;
        cmd.wr_sel  = WR_ACCUM;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.wr_sel = WR_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/tbpc_dp.sv @@
// Datapath for the tilt balance PID controller: config registers, shared
// 33x25 multiplier, filter/PID state and the output register. Uses tbpc_pkg.
module tbpc_dp
  import tbpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [31:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [55:0] out_data,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
    if (v > 59'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -59'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic [23:0]        prop_gain, integ_gain, deriv_gain;
  logic signed [24:0] target_angle;
  logic signed [31:0] accel_scale, gyro_scale;
  logic signed [15:0] accel_bias, gyro_bias;

  logic signed [15:0] accel_raw, gyro_raw;
  logic signed [31:0] acc, rate, tilt, err, last_err;
  logic               seeded;
  logic signed [32:0] sum33;
  logic signed [57:0] accum, prod;
  logic signed [47:0] integ;
  logic signed [37:0] u;
  logic [36:0]        absu;
  logic               u_neg;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] mul_p;

  logic signed [16:0] da, dg;
  logic signed [32:0] ediff, ldiff;
  logic signed [57:0] r8_full, r16_full, r32_full;
  logic signed [49:0] r8;
  logic signed [41:0] r16;
  logic signed [25:0] inc;
  logic signed [58:0] mix_full, usum;
  logic signed [48:0] isum;
  logic [61:0]        dsum;
  logic [29:0]        mag;
  logic [30:0]        pulse_sum;
  logic [15:0]        pulse;
  logic [1:0]         dir;

  assign da    = $signed({accel_raw[15], accel_raw}) - $signed({accel_bias[15], accel_bias});
  assign dg    = $signed({gyro_raw[15], gyro_raw}) - $signed({gyro_bias[15], gyro_bias});
  assign ldiff = $signed({err[31], err}) - $signed({last_err[31], last_err});
  assign ediff = $signed({{8{target_angle[24]}}, target_angle}) - $signed({tilt[31], tilt});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_ACC: begin
        mul_a = $signed({accel_scale[31], accel_scale});
        mul_b = $signed({{8{da[16]}}, da});
      end
      MS_RATE: begin
        mul_a = $signed({gyro_scale[31], gyro_scale});
        mul_b = $signed({{8{dg[16]}}, dg});
      end
      MS_INC: begin
        mul_a = $signed({rate[31], rate});
        mul_b = 25'(DT_Q32);
      end
      MS_MIX1: begin
        mul_a = sum33;
        mul_b = 25'(FILTER_COEF);
      end
      MS_MIX2: begin
        mul_a = $signed({acc[31], acc});
        mul_b = 25'(FILTER_COMP);
      end
      MS_P: begin
        mul_a = $signed({err[31], err});
        mul_b = $signed({1'b0, prop_gain});
      end
      MS_I: begin
        mul_a = $signed({err[31], err});
        mul_b = $signed({1'b0, integ_gain});
      end
      MS_D: begin
        mul_a = ldiff;
        mul_b = $signed({1'b0, deriv_gain});
      end
      MS_DL: begin
        mul_a = $signed({13'd0, absu[19:0]});
        mul_b = 25'(DUTY_GAIN);
      end
      MS_DH: begin
        mul_a = $signed({16'd0, absu[36:20]});
        mul_b = 25'(DUTY_GAIN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half up at 8, 16 and 32 fraction bits
  assign r8_full  = prod + 58'sd128;
  assign r8       = r8_full[57:8];
  assign r16_full = prod + 58'sd32768;
  assign r16      = r16_full[57:16];
  assign r32_full = prod + 58'sd2147483648;
  assign inc      = r32_full[57:32];

  assign mix_full = $signed({accum[57], accum}) + $signed({prod[57], prod}) + 59'sd32768;
  assign isum     = $signed({integ[47], integ}) + $signed({{7{r16[41]}}, r16});
  assign usum     = $signed({accum[57], accum}) + $signed({{11{integ[47]}}, integ});

  assign dsum      = {prod[40:0], 21'd0} >> 1;
  assign mag       = 30'((dsum + {18'd0, accum[43:0]}) >> 32);
  assign pulse_sum = {1'b0, mag} + 31'(MIN_PULSE);
  assign pulse     = (mag == 30'd0) ? 16'd0 :
                     ((pulse_sum > 31'd65535) ? 16'hFFFF : pulse_sum[15:0]);
  assign dir       = (mag == 30'd0) ? DIR_STOP : (u_neg ? DIR_FWD : DIR_REV);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= 24'd327680;
      integ_gain   <= 24'd328;
      deriv_gain   <= 24'd5242880;
      target_angle <= '0;
      accel_scale  <= -32'sd117342;
      gyro_scale   <= 32'sd256141;
      accel_bias   <= 16'sd170;
      gyro_bias    <= 16'sd60;
    end else if (wr_en) begin
      case (wr_index)
        REG_PROP_GAIN:    prop_gain    <= wr_data[23:0];
        REG_INTEG_GAIN:   integ_gain   <= wr_data[23:0];
        REG_DERIV_GAIN:   deriv_gain   <= wr_data[23:0];
        REG_TARGET_ANGLE: target_angle <= $signed(wr_data[24:0]);
        REG_ACCEL_SCALE:  accel_scale  <= $signed(wr_data);
        REG_GYRO_SCALE:   gyro_scale   <= $signed(wr_data);
        REG_ACCEL_BIAS:   accel_bias   <= $signed(wr_data[15:0]);
        REG_GYRO_BIAS:    gyro_bias    <= $signed(wr_data[15:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      accel_raw <= $signed(in_data[15:0]);
      gyro_raw  <= $signed(in_data[31:16]);
    end
    if (cmd.mul_sel != MS_NONE) begin
      prod <= mul_p;
    end
    case (cmd.wr_sel)
      WR_ACC:   acc   <= sat32($signed({{9{r8[49]}}, r8}));
      WR_RATE:  rate  <= sat32($signed({{9{r8[49]}}, r8}));
      WR_SUM:   sum33 <= $signed({tilt[31], tilt}) + $signed({{7{inc[25]}}, inc});
      WR_ACCUM: accum <= prod;
      WR_PTERM: accum <= $signed({{16{r16[41]}}, r16});
      WR_PD:    accum <= accum + $signed({{16{r16[41]}}, r16});
      WR_U: begin
        if (usum > 59'sd68719476736) begin
          u <= 38'sd68719476736;
        end else if (usum < -59'sd68719476736) begin
          u <= -38'sd68719476736;
        end else begin
          u <= usum[37:0];
        end
      end
      WR_ABS: begin
        absu  <= u[37] ? 37'(-u) : 37'(u);
        u_neg <= u[37];
      end
      WR_OUT: begin
        out_data <= {6'd0, tilt, pulse, dir};
      end
      default: begin
      end
    endcase
  end

  // filter and PID state
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt     <= '0;
      seeded   <= 1'b0;
      integ    <= '0;
      last_err <= '0;
      err      <= '0;
    end else begin
      case (cmd.wr_sel)
        WR_SEED: begin
          tilt   <= acc;
          seeded <= 1'b1;
        end
        WR_TILT: tilt <= sat32(mix_full >>> 16);
        WR_ERR:  err  <= sat32($signed({{26{ediff[32]}}, ediff}));
        WR_INTEG: begin
          if (isum > 49'sd140737488355327) begin
            integ <= 48'sh7FFFFFFFFFFF;
          end else if (isum < -49'sd140737488355328) begin
            integ <= 48'sh800000000000;
          end else begin
            integ <= isum[47:0];
          end
          last_err <= err;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wr_sel == WR_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.seeded   = seeded;
  assign stat.out_busy = out_valid & ~out_ready;

endmodule

@@ hw/rtl/tilt_balance_pid_controller.sv @@
// Tilt balance PID controller top level: tbpc_ctrl sequences tbpc_dp.
// One item is processed at a time: a new item is taken only after the last one is written
// to the output register. The shared multiplier sets the pace, and a stalled output holds it.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): registers return to defaults, the angle is unseeded,
// integrator and last error clear.
module tilt_balance_pid_controller
  import tbpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // accel_raw, gyro_raw
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // drive_dir, pulse_width, tilt_estimate, zero pad
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous one in progress");

  a_stop_no_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == DIR_STOP) == (m_tdata[17:2] == 16'd0)))
    else $error("stop direction and pulse width disagree");

  a_min_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != DIR_STOP) |-> (m_tdata[17:2] >= 16'(MIN_PULSE)))
    else $error("active pulse below minimum");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for tilt_balance_pid_controller: directed samples, then random ones over several
// register settings, each result checked against a fixed-point predictor or a value in the probe table.
// Depends on tbpc_pkg and the RTL only.
module testbench;
  import tbpc_pkg::*;

  typedef struct packed {
    logic [1:0]  dir;
    logic [15:0] pulse;
    logic [31:0] tilt;
  } result_t;

  typedef struct packed {
    logic [15:0] accel;
    logic [15:0] gyro;
    logic        typed;
    result_t     want;
  } probe_t;

  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;
  localparam longint I48_MAX   = 64'sd140737488355327;
  localparam longint I48_MIN   = -64'sd140737488355328;
  localparam longint DRIVE_LIM = 64'sd68719476736;

  localparam result_t STOPPED = '{dir: DIR_STOP, pulse: 16'd0, tilt: 32'd0};
  localparam int PROBE_COUNT = 18;
  // at bias: seeds a zero angle, then holds it
  localparam probe_t PROBES [PROBE_COUNT] = '{
    '{16'd170,  16'd60,   1'b1, STOPPED},
    '{16'd170,  16'd60,   1'b1, STOPPED},
    '{16'h7FFF, 16'd60,   1'b0, '0},
    '{16'h8000, 16'd60,   1'b0, '0},
    '{16'd170,  16'h7FFF, 1'b0, '0},
    '{16'd170,  16'h8000, 1'b0, '0},
    '{16'h7FFF, 16'h7FFF, 1'b0, '0},
    '{16'h8000, 16'h8000, 1'b0, '0},
    '{16'h7FFF, 16'h8000, 1'b0, '0},
    '{16'h8000, 16'h7FFF, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 1'b0, '0},
    '{16'd170,  16'd60,   1'b0, '0},
    '{16'd171,  16'd61,   1'b0, '0},
    '{16'd169,  16'd59,   1'b0, '0},
    '{16'd1170, 16'd560,  1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;

  longint  kp, ki, kd, target_q, accel_gain, gyro_gain, accel_off, gyro_off;
  longint  est_angle, integ_acc, prev_err;
  bit      est_seeded;
  result_t pending_results [$];
  logic [31:0] settings [8];
  int      mismatches, samples_sent, results_seen, settings_used;
  bit      send_burst, recv_burst;

  tilt_balance_pid_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void model_reset();
    kp = 327680;
    ki = 328;
    kd = 5242880;
    target_q = 0;
    accel_gain = -117342;
    gyro_gain = 256141;
    accel_off = 170;
    gyro_off = 60;
    est_angle = 0;
    est_seeded = 1'b0;
    integ_acc = 0;
    prev_err = 0;
  endfunction

  function automatic void apply_reg(reg_index_t idx, logic [31:0] val);
    case (idx)
      REG_PROP_GAIN:    kp = longint'(val[23:0]);
      REG_INTEG_GAIN:   ki = longint'(val[23:0]);
      REG_DERIV_GAIN:   kd = longint'(val[23:0]);
      REG_TARGET_ANGLE: target_q = longint'($signed(val[24:0]));
      REG_ACCEL_SCALE:  accel_gain = longint'($signed(val));
      REG_GYRO_SCALE:   gyro_gain = longint'($signed(val));
      REG_ACCEL_BIAS:   accel_off = longint'($signed(val[15:0]));
      REG_GYRO_BIAS:    gyro_off = longint'($signed(val[15:0]));
      default: ;
    endcase
  endfunction

  // complementary filter then PID; updates the tracked state
  function automatic result_t step_controller(logic [15:0] accel, logic [15:0] gyro);
    longint  acc, rate, inc, mix, err, p_term, d_term, u, prod, mag;
    result_t r;
    acc = clamp(round_shift((longint'($signed(accel)) - accel_off) * accel_gain, 8),
                I32_MIN, I32_MAX);
    rate = clamp(round_shift((longint'($signed(gyro)) - gyro_off) * gyro_gain, 8),
                 I32_MIN, I32_MAX);
    if (!est_seeded) begin
      est_angle = acc;
      est_seeded = 1'b1;
    end else begin
      inc = round_shift(rate * longint'(DT_Q32), 32);
      mix = (est_angle + inc) * longint'(FILTER_COEF) + acc * longint'(FILTER_COMP);
      est_angle = clamp(round_shift(mix, 16), I32_MIN, I32_MAX);
    end
    err = clamp(target_q - est_angle, I32_MIN, I32_MAX);
    p_term = round_shift(kp * err, 16);
    d_term = round_shift(kd * (err - prev_err), 16);
    integ_acc = clamp(integ_acc + round_shift(ki * err, 16), I48_MIN, I48_MAX);
    prev_err = err;
    u = clamp(p_term + d_term + integ_acc, -DRIVE_LIM, DRIVE_LIM);
    prod = u * longint'(DUTY_GAIN);
    mag = ((prod >= 0) ? prod : -prod) >>> 32;
    if (mag == 0) begin
      r.dir = DIR_STOP;
      r.pulse = 16'd0;
    end else begin
      r.dir = (prod > 0) ? DIR_REV : DIR_FWD;
      r.pulse = (mag + MIN_PULSE > 65535) ? 16'hFFFF : 16'(mag + MIN_PULSE);
    end
    r.tilt = est_angle[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_gain();
    return $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 24'h00FFFF);
  endfunction

  function automatic logic [31:0] rand_scale();
    return $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 2097152) - 1048576);
  endfunction

  function automatic logic [31:0] rand_bias();
    logic [15:0] b;
    b = 16'($urandom);
    return {{16{b[15]}}, b};
  endfunction

  task automatic send_sample(logic [15:0] accel, logic [15:0] gyro, logic typed, result_t want);
    int      gap;
    result_t got;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {gyro, accel};
    do @(posedge clk); while (!s_tready);
    got = step_controller(accel, gyro);
    pending_results.push_back(typed ? want : got);
    samples_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings();
    reg_index_t ri;
    ri = REG_PROP_GAIN;
    repeat (8) begin
      @(negedge clk);
      wr_en = 1'b1;
      wr_index = ri;
      wr_data = settings[ri];
      apply_reg(ri, settings[ri]);
      ri = ri.next();
    end
    @(negedge clk);
    wr_en = 1'b0;
    settings_used++;
  endtask

  // mostly samples near the current offsets, some over the full range
  task automatic run_random(int count);
    logic [15:0] a, g;
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) begin
        a = 16'($urandom);
        g = 16'($urandom);
      end else begin
        a = accel_off[15:0] + 16'($urandom_range(0, 4000)) - 16'd2000;
        g = gyro_off[15:0] + 16'($urandom_range(0, 4000)) - 16'd2000;
      end
      send_sample(a, g, 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    result_t got;
    result_t want;
    int      stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = '{dir: m_tdata[1:0], pulse: m_tdata[17:2], tilt: m_tdata[49:18]};
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no sample outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.dir !== want.dir) begin
          $error("drive_dir: expected %0d, got %0d", want.dir, got.dir);
          mismatches++;
        end
        if (got.pulse !== want.pulse) begin
          $error("pulse_width: expected %0d, got %0d", want.pulse, got.pulse);
          mismatches++;
        end
        if (got.tilt !== want.tilt) begin
          $error("tilt_estimate: expected %0d, got %0d", $signed(want.tilt), $signed(got.tilt));
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    wr_en = 1'b0;
    wr_index = REG_PROP_GAIN;
    wr_data = '0;
    mismatches = 0;
    samples_sent = 0;
    results_seen = 0;
    settings_used = 1;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PROBE_COUNT; i++)
      send_sample(PROBES[i].accel, PROBES[i].gyro, PROBES[i].typed, PROBES[i].want);
    drain();
    run_random(180);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          settings[REG_PROP_GAIN] = 32'hFFFFFF;
          settings[REG_INTEG_GAIN] = 32'hFFFFFF;
          settings[REG_DERIV_GAIN] = 32'hFFFFFF;
          settings[REG_TARGET_ANGLE] = 32'd11796480;
          settings[REG_ACCEL_SCALE] = 32'h7FFFFFFF;
          settings[REG_GYRO_SCALE] = 32'h7FFFFFFF;
          settings[REG_ACCEL_BIAS] = 32'h00007FFF;
          settings[REG_GYRO_BIAS] = 32'h00007FFF;
        end
        1: begin
          settings[REG_PROP_GAIN] = 32'd0;
          settings[REG_INTEG_GAIN] = 32'd0;
          settings[REG_DERIV_GAIN] = 32'd0;
          settings[REG_TARGET_ANGLE] = -32'sd11796480;
          settings[REG_ACCEL_SCALE] = 32'h80000000;
          settings[REG_GYRO_SCALE] = 32'h80000000;
          settings[REG_ACCEL_BIAS] = 32'hFFFF8000;
          settings[REG_GYRO_BIAS] = 32'hFFFF8000;
        end
        2: begin
          settings[REG_PROP_GAIN] = 32'd327680;
          settings[REG_INTEG_GAIN] = 32'd328;
          settings[REG_DERIV_GAIN] = 32'd5242880;
          settings[REG_TARGET_ANGLE] = 32'd0;
          settings[REG_ACCEL_SCALE] = -32'sd117342;
          settings[REG_GYRO_SCALE] = 32'd256141;
          settings[REG_ACCEL_BIAS] = 32'd170;
          settings[REG_GYRO_BIAS] = 32'd60;
        end
        default: begin
          settings[REG_PROP_GAIN] = rand_gain();
          settings[REG_INTEG_GAIN] = rand_gain();
          settings[REG_DERIV_GAIN] = rand_gain();
          settings[REG_TARGET_ANGLE] = $urandom_range(0, 23592960) - 11796480;
          settings[REG_ACCEL_SCALE] = rand_scale();
          settings[REG_GYRO_SCALE] = rand_scale();
          settings[REG_ACCEL_BIAS] = rand_bias();
          settings[REG_GYRO_BIAS] = rand_bias();
        end
      endcase
      load_settings();
      run_random((ph == 0) ? 300 : ((ph == 1) ? 150 : 180));
    end

    repeat (30) @(posedge clk);
    $display("Sent %0d sensor samples and checked %0d controller outputs", samples_sent,
             results_seen);
    $display("across %0d register settings, including both extremes", settings_used);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
